// ===== src/ppuscr_pkg.sv =====
// Types and action codes shared by the scroll and address register block.
package ppuscr_pkg;

	typedef enum logic [3:0] {
		ACT_CTRL_WRITE   = 4'd0,
		ACT_SCROLL_WRITE = 4'd1,
		ACT_ADDR_WRITE   = 4'd2,
		ACT_DATA_ACCESS  = 4'd3,
		ACT_STATUS_READ  = 4'd4,
		ACT_COARSE_X     = 4'd5,
		ACT_INC_Y        = 4'd6,
		ACT_COPY_HORIZ   = 4'd7,
		ACT_COPY_VERT    = 4'd8
	} action_t;

	typedef struct packed {
		logic [3:0] action;
		logic [7:0] value;
		logic       rendering_active;
	} item_t;

	typedef struct packed {
		logic [15:0] current_address;
		logic [14:0] temp_address;
		logic [2:0]  fine_x_scroll;
		logic        toggle;
		logic [15:0] access_address;
	} result_t;

	localparam logic [4:0] COARSE_MAX = 5'd31;
	localparam logic [4:0] ROW_LAST   = 5'd29;
	localparam logic [4:0] ROW_MAX    = 5'd31;

	function automatic logic [15:0] bump_coarse_x(input logic [15:0] a);
		logic [15:0] r;
		if (a[4:0] == COARSE_MAX) begin
			r = {a[15:11], ~a[10], a[9:5], 5'd0};
		end else begin
			r = a + 16'd1;
		end
		return r;
	endfunction

	function automatic logic [15:0] bump_y(input logic [15:0] a);
		logic [15:0] r;
		logic [4:0]  row;
		logic        nt;
		row = a[9:5];
		nt  = a[11];
		if (a[14:12] != 3'b111) begin
			r = a + 16'h1000;
		end else begin
			if (row == ROW_LAST) begin
				row = 5'd0;
				nt  = ~nt;
			end else if (row == ROW_MAX) begin
				row = 5'd0;
			end else begin
				row = row + 5'd1;
			end
			r = {a[15], 3'b000, nt, a[10], row, a[4:0]};
		end
		return r;
	endfunction

endpackage

// ===== src/ppu_scroll_address_registers.sv =====
// Scroll and VRAM address registers: v, t, fine X, write toggle and data-port pointer.
//
//  channel  | dir | handshake                  | payload
//  ---------+-----+----------------------------+----------------------
//  item     | in  | item_valid / item_stall    | item_t   (action, value, rendering_active)
//  result   | out | result_valid / result_stall| result_t (v, t, fine X, toggle, pointer)
//
// One item per cycle while the result is not stalled: an input register feeds a
// single pass of logic that updates the address state and loads the result register.
// An accepted item is held in the input register, then in the result register.
// Reset clears all address state to zero and empties both registers.
// A stalled result holds; the input register still takes an item while it is
// empty or while the result register is empty or draining.
module ppu_scroll_address_registers
	import ppuscr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic        valid_s1;
	item_t       item_s1;
	logic        valid_s2;
	result_t     result_s2;

	logic [15:0] cur_addr_q;
	logic [14:0] tmp_addr_q;
	logic [2:0]  fine_x_q;
	logic        write_latch_q;
	logic [15:0] port_pointer_q;
	logic        step_by_32_q;

	logic [15:0] cur_addr_d;
	logic [14:0] tmp_addr_d;
	logic [2:0]  fine_x_d;
	logic        write_latch_d;
	logic [15:0] port_pointer_d;
	logic        step_by_32_d;
	logic [15:0] seen;
	logic [15:0] step;
	logic        advance;
	logic        fire_s1;
	logic        take;

	assign advance    = !valid_s2 || !result_stall;
	assign fire_s1    = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;
	assign take       = item_valid && !item_stall;
	assign step       = step_by_32_q ? 16'd32 : 16'd1;

	always_comb begin
		cur_addr_d     = cur_addr_q;
		tmp_addr_d     = tmp_addr_q;
		fine_x_d       = fine_x_q;
		write_latch_d  = write_latch_q;
		port_pointer_d = port_pointer_q;
		step_by_32_d   = step_by_32_q;
		seen           = port_pointer_q;
		unique case (item_s1.action)
			ACT_CTRL_WRITE: begin
				step_by_32_d      = item_s1.value[2];
				tmp_addr_d[11:10] = item_s1.value[1:0];
			end
			ACT_SCROLL_WRITE: begin
				if (!write_latch_q) begin
					tmp_addr_d[4:0] = item_s1.value[7:3];
					fine_x_d        = item_s1.value[2:0];
					write_latch_d   = 1'b1;
				end else begin
					tmp_addr_d[9:5]   = item_s1.value[7:3];
					tmp_addr_d[14:12] = item_s1.value[2:0];
					write_latch_d     = 1'b0;
				end
			end
			ACT_ADDR_WRITE: begin
				if (!write_latch_q) begin
					port_pointer_d    = {item_s1.value, 8'd0};
					tmp_addr_d[14]    = 1'b0;
					tmp_addr_d[13:8]  = item_s1.value[5:0];
					write_latch_d     = 1'b1;
				end else begin
					port_pointer_d    = {port_pointer_q[15:8], port_pointer_q[7:0] | item_s1.value};
					tmp_addr_d[7:0]   = item_s1.value;
					cur_addr_d        = {1'b0, tmp_addr_q[14:8], item_s1.value};
					write_latch_d     = 1'b0;
				end
			end
			ACT_DATA_ACCESS: begin
				port_pointer_d = port_pointer_q + step;
				if (item_s1.rendering_active) begin
					cur_addr_d = bump_y(bump_coarse_x(cur_addr_q)) & 16'h7FFF;
				end else begin
					cur_addr_d = cur_addr_q + step;
				end
			end
			ACT_STATUS_READ: begin
				write_latch_d = 1'b0;
			end
			ACT_COARSE_X: begin
				cur_addr_d = bump_coarse_x(cur_addr_q);
			end
			ACT_INC_Y: begin
				cur_addr_d = bump_y(cur_addr_q);
			end
			ACT_COPY_HORIZ: begin
				cur_addr_d[10]  = tmp_addr_q[10];
				cur_addr_d[4:0] = tmp_addr_q[4:0];
			end
			ACT_COPY_VERT: begin
				cur_addr_d[15]    = 1'b0;
				cur_addr_d[14:11] = tmp_addr_q[14:11];
				cur_addr_d[9:5]   = tmp_addr_q[9:5];
			end
			default: begin
			end
		endcase
		if (item_s1.action != ACT_DATA_ACCESS) begin
			seen = port_pointer_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2       <= 1'b0;
			cur_addr_q     <= '0;
			tmp_addr_q     <= '0;
			fine_x_q       <= '0;
			write_latch_q  <= 1'b0;
			port_pointer_q <= '0;
			step_by_32_q   <= 1'b0;
		end else begin
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (fire_s1) begin
				cur_addr_q     <= cur_addr_d;
				tmp_addr_q     <= tmp_addr_d;
				fine_x_q       <= fine_x_d;
				write_latch_q  <= write_latch_d;
				port_pointer_q <= port_pointer_d;
				step_by_32_q   <= step_by_32_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			result_s2 <= '{
				current_address: cur_addr_d,
				temp_address:    tmp_addr_d,
				fine_x_scroll:   fine_x_d,
				toggle:          write_latch_d,
				access_address:  seen
			};
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_status_clears_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && item_s1.action == ACT_STATUS_READ |=> !result.toggle && result_valid)
		else $error("status read left toggle set");

	a_vert_copy_bit15: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && item_s1.action == ACT_COPY_VERT |=> !result.current_address[15])
		else $error("vertical copy kept bit 15 of v");

	a_render_access_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && item_s1.action == ACT_DATA_ACCESS && item_s1.rendering_active
		|=> !result.current_address[15])
		else $error("rendering data access left v above 15 bits");

endmodule
